// ===== sv/mmf_pkg.sv =====
// Shared types and constants for the message mailbox FIFO.
package mmf_pkg;

  // Field widths of one beat and of the configuration registers
  localparam int unsigned CmdW  = 2;
  localparam int unsigned DataW = 64;
  localparam int unsigned FillW = 5;
  localparam int unsigned CapW  = 5;
  localparam int unsigned SizeW = 4;

  // Command codes on the input channel
  localparam logic [CmdW-1:0] CMD_TAKE = 2'd0;
  localparam logic [CmdW-1:0] CMD_GIVE = 2'd1;
  localparam logic [CmdW-1:0] CMD_PUSH = 2'd2;

  // Configuration register indexes (word address bit 2)
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_MSG_SIZE = 1'b1;

  // Register reset values
  localparam logic [CapW-1:0]  CAPACITY_RST = 5'd16;
  localparam logic [SizeW-1:0] MSG_SIZE_RST = 4'd8;

  // Decoded operation handed from front to back
  typedef enum logic [1:0] {
    OP_TAKE = 2'd0,
    OP_GIVE = 2'd1,
    OP_PUSH = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [DataW-1:0] data_in;
  } in_beat_t;

  typedef struct packed {
    logic             status;
    logic [DataW-1:0] data_out;
    logic [FillW-1:0] fill_count;
  } out_beat_t;

  typedef struct packed {
    op_e              op;
    logic [DataW-1:0] data;
  } q_entry_t;

endpackage

// ===== sv/mmf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mmf_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mmf_front.sv =====
// Front end: accepts command beats, decodes and masks them into a two-entry queue.
module mmf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mmf_pkg::in_beat_t in_data_i,
  input  logic [3:0]        size_eff_i,
  output logic              q_valid_o,
  output mmf_pkg::q_entry_t q_entry_o,
  input  logic              q_pop_i
);
  import mmf_pkg::*;

  q_entry_t   ent_q [2];
  q_entry_t   new_ent;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic [DataW-1:0] mask;

  // Build byte mask from the effective message size
  always_comb begin
    for (int b = 0; b < DataW / 8; b++) begin
      mask[b*8 +: 8] = (4'(b) < size_eff_i) ? 8'hFF : 8'h00;
    end
  end

  // Decode the command
  always_comb begin
    new_ent.data = in_data_i.data_in & mask;
    case (in_data_i.cmd)
      CMD_TAKE: new_ent.op = OP_TAKE;
      CMD_GIVE: new_ent.op = OP_GIVE;
      CMD_PUSH: new_ent.op = OP_PUSH;
      default:  new_ent.op = OP_NONE;
    endcase
  end

  assign in_stall_o = cnt_q[1];
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_entry_o  = ent_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // Advance queue pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

  // Hold queue payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= new_ent;
    end
  end

endmodule

// ===== sv/mmf_back.sv =====
// Back end: executes queued operations against the slot RAM and drives the result beat.
module mmf_back #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clr_i,
  input  logic [4:0]         cap_eff_i,
  input  logic               q_valid_i,
  input  mmf_pkg::q_entry_t  q_entry_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mmf_pkg::out_beat_t out_data_o
);
  import mmf_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = (PW + 1 > 5) ? PW + 1 : 5;

  typedef enum logic [1:0] {
    S_RUN = 2'b01,
    S_RD  = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic [PW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [FillW-1:0] held_q, held_d;
  logic             out_valid_q, out_valid_d;
  out_beat_t        out_q, res;
  logic             load, out_free, issue;
  logic             ram_we, ram_re;
  logic [PW-1:0]    ram_raddr;
  logic [DataW-1:0] ram_rdata;

  // Next slot index, wrapping at the effective capacity
  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [4:0] cap);
    logic [CW-1:0] nxt;
    nxt = CW'(p) + CW'(1);
    return (nxt < CW'(cap)) ? nxt[PW-1:0] : '0;
  endfunction

  mmf_ram #(
    .WIDTH(DataW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(q_entry_i.data),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_free  = !out_valid_q || !out_stall_i;
  assign issue     = (state_q == S_RUN) && q_valid_i && out_free;
  assign q_pop_o   = issue;
  assign ram_raddr = head_q;

  // Execute one operation
  always_comb begin
    state_d        = state_q;
    head_d         = head_q;
    tail_d         = tail_q;
    held_d         = held_q;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    load           = 1'b0;
    res.status     = 1'b1;
    res.data_out   = '0;
    res.fill_count = held_q;
    case (state_q)
      S_RD: begin
        // finish a take with the slot read data
        load         = 1'b1;
        res.status   = 1'b0;
        res.data_out = ram_rdata;
        state_d      = S_RUN;
      end
      S_RUN: begin
        if (issue) begin
          case (q_entry_i.op)
            OP_TAKE: begin
              if (held_q != '0) begin
                ram_re  = 1'b1;
                head_d  = adv(head_q, cap_eff_i);
                held_d  = held_q - 5'd1;
                state_d = S_RD;
              end else begin
                load = 1'b1;
              end
            end
            OP_GIVE: begin
              load = 1'b1;
              if (held_q < cap_eff_i) begin
                ram_we     = 1'b1;
                tail_d     = adv(tail_q, cap_eff_i);
                held_d     = held_q + 5'd1;
                res.status = 1'b0;
              end
            end
            OP_PUSH: begin
              load       = 1'b1;
              ram_we     = 1'b1;
              tail_d     = adv(tail_q, cap_eff_i);
              res.status = 1'b0;
              if (held_q == cap_eff_i) begin
                // drop the oldest message
                head_d = tail_d;
              end else begin
                held_d = held_q + 5'd1;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
          res.fill_count = held_d;
        end
      end
      default: begin
        state_d = S_RUN;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  // Update pointers, state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      head_q      <= '0;
      tail_q      <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (clr_i) begin
        head_q <= '0;
        tail_q <= '0;
        held_q <= '0;
      end else begin
        head_q <= head_d;
        tail_q <= tail_d;
        held_q <= held_d;
      end
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/message_mailbox_fifo.sv =====
// Message mailbox FIFO: a circular queue of message slots with take, give and
// push-with-overwrite commands, one result beat per command. A two-entry command
// queue separates the decode front end from the execution back end, and the
// result sits in an output register, so new commands are taken while a result
// waits. Give, push, a failed take and an unused code finish in the back end's
// run state; a successful take also passes through a read state, for the
// registered read of the slot RAM. Writing capacity (address 0) or msg_size
// (address 4) empties the queue; no clearing pass is needed after reset.
module message_mailbox_fifo #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned MAX_BYTES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mmf_pkg::in_beat_t  in_data_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mmf_pkg::out_beat_t out_data_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import mmf_pkg::*;

  logic [CapW-1:0]  capacity_q;
  logic [SizeW-1:0] msg_size_q;
  logic [4:0]       cap_eff;
  logic [3:0]       size_eff;
  logic             cfg_we;
  logic             q_valid, q_pop;
  q_entry_t         q_entry;

  // Register writes
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RST;
      msg_size_q <= MSG_SIZE_RST;
    end else if (cfg_we) begin
      if (paddr[2] == REG_CAPACITY) begin
        capacity_q <= pwdata[CapW-1:0];
      end else begin
        msg_size_q <= pwdata[SizeW-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_MSG_SIZE) ? 32'(msg_size_q) : 32'(capacity_q);

  // Clamp capacity and message size into range
  always_comb begin
    cap_eff = capacity_q;
    if (capacity_q == '0) begin
      cap_eff = 5'd1;
    end else if (32'(capacity_q) > DEPTH) begin
      cap_eff = 5'(DEPTH);
    end
    size_eff = msg_size_q;
    if (msg_size_q == '0) begin
      size_eff = 4'd1;
    end else if (32'(msg_size_q) > MAX_BYTES) begin
      size_eff = 4'(MAX_BYTES);
    end
  end

  mmf_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .size_eff_i(size_eff),
    .q_valid_o (q_valid),
    .q_entry_o (q_entry),
    .q_pop_i   (q_pop)
  );

  mmf_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (cfg_we),
    .cap_eff_i  (cap_eff),
    .q_valid_i  (q_valid),
    .q_entry_i  (q_entry),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

`ifndef SYNTH
  // Fill count never exceeds the slots in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.fill_count <= cap_eff))
    else $error("fill count above capacity");

  // A failed command returns no message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status) |-> (out_data_o.data_out == '0))
    else $error("failed command returned data");

  // Queue pops only when the back end can hold the result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (q_valid && (!out_valid_o || !out_stall_i)))
    else $error("pop without room for result");
`endif

endmodule

// ===== tb/tb_message_mailbox_fifo.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the message mailbox FIFO: random commands against a mailbox predictor.
module tb_message_mailbox_fifo;
  import mmf_pkg::*;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned MSG_BYTES = 8;
  localparam logic [CmdW-1:0] CMD_SPARE = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned PHASES = 13;
  localparam int unsigned PHASE_ITEMS = 86;
  localparam int unsigned MAX_PRINTS = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_beat_t    in_beat = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_beat;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Mailbox predictor state
  logic [DataW-1:0] slot_mem [SLOTS];
  int unsigned      rd_ptr;
  int unsigned      wr_ptr;
  int unsigned      msg_count;
  logic [CapW-1:0]  cap_reg;
  logic [SizeW-1:0] size_reg;

  in_beat_t    pending_cmds [$];
  out_beat_t   expected_results [$];
  out_beat_t   want;
  int unsigned errors = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_gap = 0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;

  message_mailbox_fifo DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_beat),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] exp_val);
    errors++;
    if (errors <= MAX_PRINTS) begin
      $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, exp_val);
    end
  endtask

  // Zero capacity behaves as one slot, anything above the array as the whole array
  function automatic int unsigned slots_in_use();
    if (cap_reg == 0) return 1;
    if (cap_reg > SLOTS) return SLOTS;
    return cap_reg;
  endfunction

  function automatic int unsigned wrap_inc(input int unsigned idx);
    return (idx + 1 < slots_in_use()) ? idx + 1 : 0;
  endfunction

  function automatic void clear_mailbox();
    rd_ptr = 0;
    wr_ptr = 0;
    msg_count = 0;
  endfunction

  // Store a message with the bytes above the message size cleared
  function automatic void append_msg(input logic [DataW-1:0] msg);
    int unsigned nbytes;
    logic [DataW-1:0] mask;
    nbytes = size_reg;
    if (nbytes == 0) nbytes = 1;
    if (nbytes > MSG_BYTES) nbytes = MSG_BYTES;
    mask = (nbytes >= 8) ? '1 : ((64'd1 << (8 * nbytes)) - 64'd1);
    slot_mem[wr_ptr] = msg & mask;
    wr_ptr = wrap_inc(wr_ptr);
    msg_count++;
  endfunction

  // Execute one command on the predictor and return its result beat
  function automatic out_beat_t mailbox_exec(input in_beat_t b);
    out_beat_t r;
    int unsigned cap;
    cap = slots_in_use();
    r.status = 1'b1;
    r.data_out = '0;
    case (b.cmd)
      CMD_TAKE: begin
        if (msg_count > 0) begin
          r.data_out = slot_mem[rd_ptr];
          rd_ptr = wrap_inc(rd_ptr);
          msg_count--;
          r.status = 1'b0;
        end
      end
      CMD_GIVE: begin
        if (msg_count < cap) begin
          append_msg(b.data_in);
          r.status = 1'b0;
        end
      end
      CMD_PUSH: begin
        append_msg(b.data_in);
        // full mailbox: the oldest message falls out
        if (msg_count > cap) begin
          msg_count = cap;
          rd_ptr = wr_ptr;
        end
        r.status = 1'b0;
      end
      default: begin
      end
    endcase
    r.fill_count = msg_count[FillW-1:0];
    return r;
  endfunction

  function automatic void add_cmd(input logic [CmdW-1:0] c, input logic [DataW-1:0] d);
    in_beat_t b;
    b.cmd = c;
    b.data_in = d;
    pending_cmds.push_back(b);
  endfunction

  // Queue a run of commands biased toward filling, draining or overwriting
  task automatic add_random_run(input int unsigned n);
    int unsigned mode;
    int unsigned pick;
    logic [CmdW-1:0] c;
    logic [DataW-1:0] d;
    mode = $urandom_range(0, 2);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) c = CMD_SPARE;
      else if (mode == 0) c = (pick < 65) ? CMD_GIVE : (pick < 80) ? CMD_PUSH : CMD_TAKE;
      else if (mode == 1) c = (pick < 70) ? CMD_TAKE : (pick < 90) ? CMD_GIVE : CMD_PUSH;
      else c = (pick < 65) ? CMD_PUSH : (pick < 90) ? CMD_TAKE : CMD_GIVE;
      case ($urandom_range(0, 9))
        0: d = '1;
        1: d = '0;
        default: d = {$urandom, $urandom};
      endcase
      add_cmd(c, d);
    end
  endtask

  // Write a register, update the predictor, then read it back
  task automatic write_reg(input logic idx, input logic [31:0] val);
    logic [31:0] kept;
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_CAPACITY) begin
      cap_reg = val[CapW-1:0];
      kept = {{(32-CapW){1'b0}}, val[CapW-1:0]};
    end else begin
      size_reg = val[SizeW-1:0];
      kept = {{(32-SizeW){1'b0}}, val[SizeW-1:0]};
    end
    clear_mailbox();
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== kept) report_mismatch("register readback", {32'd0, prdata}, {32'd0, kept});
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Block until every queued command is sent and every result has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // Command driver: predict on each accepted beat, hold a stalled beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) expected_results.push_back(mailbox_exec(in_beat));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
          send_gap = $urandom_range(0, 8);
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          in_valid <= 1'b1;
          in_beat <= pending_cmds.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each beat with the oldest expectation, drive stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result data_out", out_beat.data_out, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_beat.status !== want.status)
            report_mismatch("status", {63'd0, out_beat.status}, {63'd0, want.status});
          if (out_beat.data_out !== want.data_out)
            report_mismatch("data_out", out_beat.data_out, want.data_out);
          if (out_beat.fill_count !== want.fill_count)
            report_mismatch("fill_count", {59'd0, out_beat.fill_count},
                            {59'd0, want.fill_count});
        end
      end
      if (hold_req) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_gap > 0) begin
        stall_gap--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_gap = $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb_message_mailbox_fifo failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned caps [PHASES];
    int unsigned sizes [PHASES];
    int unsigned queued;
    int unsigned n;
    logic [31:0] upper;
    caps = '{31, 1, 2, 3, 0, 7, 16, 17, 5, 4, 9, 12, 16};
    sizes = '{15, 8, 1, 2, 3, 4, 5, 6, 7, 9, 0, 8, 8};
    cap_reg = CAPACITY_RST;
    size_reg = MSG_SIZE_RST;
    clear_mailbox();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: take and spare code on empty, extreme messages, take past empty
    add_cmd(CMD_TAKE, '1);
    add_cmd(CMD_SPARE, '1);
    add_cmd(CMD_GIVE, '1);
    add_cmd(CMD_GIVE, '0);
    add_cmd(CMD_PUSH, 64'h5555_5555_5555_5555);
    add_cmd(CMD_SPARE, '0);
    repeat (4) add_cmd(CMD_TAKE, '0);
    wait_drained();

    // Two slots: give on full fails, push on full drops the oldest
    write_reg(REG_CAPACITY, 32'd2);
    add_cmd(CMD_GIVE, 64'hAAAA_AAAA_AAAA_AAAA);
    add_cmd(CMD_GIVE, 64'h0123_4567_89AB_CDEF);
    add_cmd(CMD_GIVE, 64'hDEAD_BEEF_DEAD_BEEF);
    add_cmd(CMD_PUSH, 64'hFEDC_BA98_7654_3210);
    add_cmd(CMD_SPARE, 64'h1);
    repeat (3) add_cmd(CMD_TAKE, '1);
    wait_drained();

    // Capacity zero acts as one slot, size zero as one byte
    write_reg(REG_CAPACITY, 32'hFFFF_FFE0);
    write_reg(REG_MSG_SIZE, 32'd0);
    add_cmd(CMD_GIVE, '1);
    add_cmd(CMD_PUSH, 64'h8000_0000_0000_0001);
    add_cmd(CMD_TAKE, '0);
    add_cmd(CMD_TAKE, '0);
    wait_drained();

    // Random phases over a sweep of settings; the last one runs without idling
    for (int p = 0; p < PHASES; p++) begin
      upper = (p % 2 == 1) ? $urandom : 32'd0;
      write_reg(REG_CAPACITY, (upper & ~32'h1F) | caps[p]);
      write_reg(REG_MSG_SIZE, (upper & ~32'hF) | sizes[p]);
      if (p == PHASES - 1) quiet <= 1'b1;
      queued = 0;
      while (queued < PHASE_ITEMS) begin
        n = $urandom_range(8, 40);
        add_random_run(n);
        queued += n;
      end
      // Hold off the receiver while commands keep coming, so the input backs up
      if (p == 3) begin
        @(posedge clk_i);
        hold_req <= 1'b1;
        @(posedge clk_i);
        hold_req <= 1'b0;
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (expected_results.size() != 0) report_mismatch("results left over", '0, '0);
    if (errors == 0) begin
      $display("tb_message_mailbox_fifo passed");
    end else begin
      $display("tb_message_mailbox_fifo failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/mmf_pkg.sv
sv/mmf_ram.sv
sv/mmf_front.sv
sv/mmf_back.sv
sv/message_mailbox_fifo.sv
tb/tb_message_mailbox_fifo.sv
